>>> rtl/sdwq_pkg.sv
package sdwq_pkg;

  localparam int unsigned QueueDepth = 32;
  localparam int unsigned TaskIdBits = 8;

  localparam int unsigned IdxW  = $clog2(QueueDepth);
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);
  localparam int unsigned OpW   = 2;
  localparam int unsigned ReqW  = 8;
  localparam int unsigned TickW = 31;
  localparam int unsigned AnsW  = 32;

  localparam logic [TickW-1:0] TickMax = '1;

  typedef enum logic [OpW-1:0] {
    OP_DELAY = 2'd0,
    OP_QUERY = 2'd1,
    OP_TICK  = 2'd2,
    OP_SPARE = 2'd3
  } op_e;

  typedef enum logic {
    KIND_DIRECT = 1'b0,
    KIND_WAKE   = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_INS_RD  = 3'd1,
    ST_INS_CMP = 3'd2,
    ST_EXP_RD  = 3'd3,
    ST_EXP_CMP = 3'd4,
    ST_FLUSH   = 3'd5
  } state_e;

  typedef struct packed {
    logic [TickW-1:0]      deadline;
    logic [TaskIdBits-1:0] task_id;
  } entry_t;

  typedef struct packed {
    logic [ReqW-1:0] dest_task;
    logic [AnsW-1:0] answer;
    logic            answer_kind;
    logic            is_last;
  } result_t;

  typedef struct packed {
    logic in_ready;
    logic capture;
    logic ins_rd;
    logic ins_shift;
    logic ins_place;
    logic exp_rd;
    logic exp_pop;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic in_insert;
    logic j_zero;
    logic rd_gt;
    logic expired;
    logic count_zero;
    logic full;
    logic pend_v;
    logic out_free;
  } stat_t;

  function automatic logic [IdxW-1:0] wrap_add(logic [IdxW-1:0] base, logic [CntW-1:0] off);
    logic [CntW:0] sum;
    sum = (CntW+1)'(base) + (CntW+1)'(off);
    if (sum >= (CntW+1)'(QueueDepth)) begin
      sum = sum - (CntW+1)'(QueueDepth);
    end
    return sum[IdxW-1:0];
  endfunction

endpackage

>>> rtl/sdwq_in_if.sv
interface sdwq_in_if;
  import sdwq_pkg::*;

  logic            valid;
  logic            ready;
  logic [OpW-1:0]  opcode;
  logic [ReqW-1:0] requester;
  logic [TickW-1:0] deadline;

  modport source (output valid, output opcode, output requester, output deadline,
                  input ready);
  modport sink   (input valid, input opcode, input requester, input deadline,
                  output ready);
endinterface

>>> rtl/sdwq_out_if.sv
interface sdwq_out_if;
  import sdwq_pkg::*;

  logic            valid;
  logic            ready;
  logic [ReqW-1:0] dest_task;
  logic [AnsW-1:0] answer;
  logic            answer_kind;
  logic            is_last;

  modport source (output valid, output dest_task, output answer, output answer_kind,
                  output is_last, input ready);
  modport sink   (input valid, input dest_task, input answer, input answer_kind,
                  input is_last, output ready);
endinterface

>>> rtl/sorted_delay_wakeup_queue_top.sv
// Timer wakeup server: tick counter plus a deadline-sorted queue of waiting tasks.
// in_i takes one word per item: opcode (delay, time query, tick), requester and
// deadline. out_o returns result words: dest_task, answer, answer_kind, is_last.
// A query or tick gets a direct answer with the count (a tick then advances the
// saturating count); a delay joins the queue silently, or gets -1 when full.
// After each item every entry whose deadline is reached is woken in deadline order.
// is_last marks the final word of an item; a delay with no wakeup gives no word.
// One item is worked at a time; in_i.ready is high only while the block is idle.
// Per item: accept; for a sorted insert, a read and a compare per entry passed,
// then the placing write; a read and a pop per wakeup; then a check of the queue
// head and the handoff of the last word. The single-port entry memory, with its
// registered read, serves both the insert and wakeup walks.
// Each result is held in a staging register and an output register; when out_o
// is stalled the block waits with both held and nothing is dropped.
// Reset clears the count and empties the queue at once; no clearing pass runs.
module sorted_delay_wakeup_queue_top (
  input logic        clk_i,
  input logic        rst_ni,
  sdwq_in_if.sink    in_i,
  sdwq_out_if.source out_o
);
  import sdwq_pkg::*;

  cmd_t    cmd;
  stat_t   stat;
  result_t out_result;
  logic    out_valid;

  sdwq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sdwq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .in_opcode_i    (in_i.opcode),
    .in_requester_i (in_i.requester),
    .in_deadline_i  (in_i.deadline),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_valid),
    .out_result_o   (out_result)
  );

  assign in_i.ready        = cmd.in_ready;
  assign out_o.valid       = out_valid;
  assign out_o.dest_task   = out_result.dest_task;
  assign out_o.answer      = out_result.answer;
  assign out_o.answer_kind = out_result.answer_kind;
  assign out_o.is_last     = out_result.is_last;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !stat.pend_v)
    else $error("staged result left over at idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.exp_pop && stat.pend_v) |-> stat.out_free)
    else $error("output register overwritten on wakeup");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins_place |-> !stat.full)
    else $error("insert into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.flush |=> (!stat.pend_v && in_i.ready))
    else $error("item not closed after last word");

endmodule

>>> rtl/sdwq_ctrl.sv
module sdwq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  sdwq_pkg::stat_t stat_i,
  output sdwq_pkg::cmd_t  cmd_o
);
  import sdwq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.in_insert ? ST_INS_RD : ST_EXP_RD;
        end
      end
      ST_INS_RD: begin
        state_d = stat_i.j_zero ? ST_EXP_RD : ST_INS_CMP;
      end
      ST_INS_CMP: begin
        state_d = stat_i.rd_gt ? ST_INS_RD : ST_EXP_RD;
      end
      ST_EXP_RD: begin
        state_d = stat_i.count_zero ? ST_FLUSH : ST_EXP_CMP;
      end
      ST_EXP_CMP: begin
        if (!stat_i.expired) begin
          state_d = ST_FLUSH;
        end else if (!stat_i.pend_v || stat_i.out_free) begin
          state_d = ST_EXP_RD;
        end
      end
      ST_FLUSH: begin
        if (!stat_i.pend_v || stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.capture  = in_valid_i;
      end
      ST_INS_RD: begin
        cmd_o.ins_place = stat_i.j_zero;
        cmd_o.ins_rd    = !stat_i.j_zero;
      end
      ST_INS_CMP: begin
        cmd_o.ins_shift = stat_i.rd_gt;
        cmd_o.ins_place = !stat_i.rd_gt;
      end
      ST_EXP_RD: begin
        cmd_o.exp_rd = !stat_i.count_zero;
      end
      ST_EXP_CMP: begin
        cmd_o.exp_pop = stat_i.expired && (!stat_i.pend_v || stat_i.out_free);
      end
      ST_FLUSH: begin
        cmd_o.flush = !stat_i.pend_v || stat_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> rtl/sdwq_datapath.sv
module sdwq_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sdwq_pkg::cmd_t             cmd_i,
  output sdwq_pkg::stat_t            stat_o,
  input  logic [sdwq_pkg::OpW-1:0]   in_opcode_i,
  input  logic [sdwq_pkg::ReqW-1:0]  in_requester_i,
  input  logic [sdwq_pkg::TickW-1:0] in_deadline_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output sdwq_pkg::result_t          out_result_o
);
  import sdwq_pkg::*;

  entry_t           mem_q [QueueDepth];
  entry_t           rdata_q;
  logic             rd_en, wr_en;
  logic [IdxW-1:0]  rd_addr, wr_addr;
  entry_t           wr_data;

  logic [ReqW-1:0]  req_q, req_d;
  logic [TickW-1:0] dl_q, dl_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  j_q, j_d;
  result_t          pend_q, pend_d;
  logic             pend_v_q, pend_v_d;
  result_t          out_q, out_d;
  logic             out_v_q, out_v_d;
  op_e              in_op;
  logic             full;

  assign in_op = op_e'(in_opcode_i);
  assign full  = (count_q == CntW'(QueueDepth));

  assign stat_o.in_insert  = (in_op == OP_DELAY) && !full;
  assign stat_o.j_zero     = (j_q == '0);
  assign stat_o.rd_gt      = (rdata_q.deadline > dl_q);
  assign stat_o.expired    = (rdata_q.deadline <= tick_q);
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.full       = full;
  assign stat_o.pend_v     = pend_v_q;
  assign stat_o.out_free   = !out_v_q || out_ready_i;

  assign rd_en   = cmd_i.ins_rd || cmd_i.exp_rd;
  assign rd_addr = cmd_i.ins_rd ? wrap_add(head_q, j_q - CntW'(1)) : head_q;
  assign wr_en   = cmd_i.ins_shift || cmd_i.ins_place;
  assign wr_addr = wrap_add(head_q, j_q);
  assign wr_data = cmd_i.ins_shift ? rdata_q
                                   : entry_t'{deadline: dl_q, task_id: TaskIdBits'(req_q)};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    req_d    = req_q;
    dl_d     = dl_q;
    tick_d   = tick_q;
    head_d   = head_q;
    count_d  = count_q;
    j_d      = j_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    out_d    = out_q;
    out_v_d  = out_v_q && !out_ready_i;

    if (cmd_i.capture) begin
      req_d    = in_requester_i;
      dl_d     = in_deadline_i;
      j_d      = count_q;
      pend_v_d = 1'b0;
      pend_d   = '{dest_task: in_requester_i, answer: AnsW'(tick_q),
                   answer_kind: KIND_DIRECT, is_last: 1'b0};
      unique case (in_op)
        OP_DELAY: begin
          if (full) begin
            pend_d.answer = '1;
            pend_v_d      = 1'b1;
          end
        end
        OP_TICK: begin
          pend_v_d = 1'b1;
          if (tick_q != TickMax) begin
            tick_d = tick_q + TickW'(1);
          end
        end
        default: pend_v_d = 1'b1;
      endcase
    end

    if (cmd_i.ins_shift) begin
      j_d = j_q - CntW'(1);
    end
    if (cmd_i.ins_place) begin
      count_d = count_q + CntW'(1);
    end

    if (cmd_i.exp_pop) begin
      if (pend_v_q) begin
        out_d   = pend_q;
        out_v_d = 1'b1;
      end
      pend_d   = '{dest_task: ReqW'(rdata_q.task_id), answer: AnsW'(tick_q),
                   answer_kind: KIND_WAKE, is_last: 1'b0};
      pend_v_d = 1'b1;
      head_d   = wrap_add(head_q, CntW'(1));
      count_d  = count_q - CntW'(1);
    end

    if (cmd_i.flush && pend_v_q) begin
      out_d         = pend_q;
      out_d.is_last = 1'b1;
      out_v_d       = 1'b1;
      pend_v_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      head_q   <= '0;
      count_q  <= '0;
      j_q      <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      tick_q   <= tick_d;
      head_q   <= head_d;
      count_q  <= count_d;
      j_q      <= j_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    dl_q   <= dl_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o  = out_v_q;
  assign out_result_o = out_q;

endmodule
